// ===== design/hlj_pkg.sv =====
package hlj_pkg;

   // Capacity and field widths
   localparam int MAX_WEEKS   = 64;
   localparam int PAYOFF_BITS = 16;
   localparam int TOTAL_BITS  = 22;
   localparam int WEEK_BITS   = 6;
   localparam int COUNT_BITS  = 7;

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   typedef logic [TOTAL_BITS-1:0]  total_type;
   typedef logic [PAYOFF_BITS-1:0] payoff_type;
   typedef logic [WEEK_BITS-1:0]   week_type;
   typedef logic [COUNT_BITS-1:0]  count_type;

   // Per-week decision codes
   typedef enum logic [1:0] {
      CODE_LOW  = 2'd0,
      CODE_HIGH = 2'd1,
      CODE_NONE = 2'd2
   } code_type;

   // Running totals of the forward pass
   typedef struct packed {
      total_type low;
      total_type high;
      total_type none;
      count_type count;
      logic      overflow;
   } totals_type;

   // Write into the choice memory
   typedef struct packed {
      logic     en;
      week_type addr;
      code_type code;
   } choice_wr_type;

   typedef struct packed {
      total_type value;
      code_type  code;
   } best_type;

   // Largest of three totals; low wins ties, then high, then none
   function automatic best_type pick_best(input total_type lo, input total_type hi,
                                          input total_type no);
      best_type b;
      b.value = lo;
      b.code  = CODE_LOW;
      if (hi > b.value) begin
         b.value = hi;
         b.code  = CODE_HIGH;
      end
      if (no > b.value) begin
         b.value = no;
         b.code  = CODE_NONE;
      end
      return b;
   endfunction

   // Add a payoff to a total, saturating at the top of the total range
   function automatic total_type sat_add(input total_type a, input payoff_type b);
      logic [TOTAL_BITS:0] sum;
      sum = {1'b0, a} + (TOTAL_BITS+1)'(b);
      return sum[TOTAL_BITS] ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
   endfunction

endpackage

// ===== design/hlj_forward.sv =====
module hlj_forward (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  hlj_pkg::payoff_type    low_payoff,
   input  hlj_pkg::payoff_type    high_payoff,
   input  logic                   clear,
   output hlj_pkg::totals_type    totals,
   output hlj_pkg::choice_wr_type choice_wr
);

   hlj_pkg::total_type low_ff, low_in;
   hlj_pkg::total_type high_ff, high_in;
   hlj_pkg::total_type none_ff, none_in;
   hlj_pkg::count_type count_ff, count_in;
   logic               overflow_ff, overflow_in;
   hlj_pkg::best_type  prev;
   logic               full;

   assign prev = hlj_pkg::pick_best(low_ff, high_ff, none_ff);
   assign full = (count_ff >= hlj_pkg::COUNT_BITS'(hlj_pkg::MAX_WEEKS));

   // Clear the totals, or advance the three totals by one week
   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      none_in     = none_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      choice_wr.en   = 1'b0;
      choice_wr.addr = count_ff[hlj_pkg::WEEK_BITS-1:0];
      choice_wr.code = prev.code;
      if (clear) begin
         low_in      = '0;
         high_in     = '0;
         none_in     = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (accept) begin
         priority if (full) begin
            overflow_in = 1'b1;
         end else if (count_ff == '0) begin
            low_in         = hlj_pkg::sat_add('0, low_payoff);
            high_in        = hlj_pkg::sat_add('0, high_payoff);
            none_in        = '0;
            count_in       = hlj_pkg::COUNT_BITS'(1);
            choice_wr.en   = 1'b1;
            choice_wr.code = hlj_pkg::CODE_NONE;
         end else begin
            low_in       = hlj_pkg::sat_add(prev.value, low_payoff);
            high_in      = hlj_pkg::sat_add(none_ff, high_payoff);
            none_in      = prev.value;
            count_in     = count_ff + hlj_pkg::COUNT_BITS'(1);
            choice_wr.en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= '0;
         high_ff     <= '0;
         none_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         none_ff     <= none_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign totals.low      = low_ff;
   assign totals.high     = high_ff;
   assign totals.none     = none_ff;
   assign totals.count    = count_ff;
   assign totals.overflow = overflow_ff;

endmodule

// ===== design/hlj_trace.sv =====
module hlj_trace (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  hlj_pkg::totals_type    totals,
   input  hlj_pkg::choice_wr_type choice_wr,
   output logic                   clear,
   output logic                   busy,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,   // week_index, decision, best_total, truncated
   output logic                   rsp_tlast    // last_of_run
);

   typedef enum logic [1:0] {
      IDLE,
      PRIME,
      RUN
   } state_type;

   state_type          state_ff;
   hlj_pkg::week_type  pos_ff;
   hlj_pkg::code_type  choice_ff;
   hlj_pkg::total_type best_ff;
   logic               trunc_ff;

   logic               out_valid_ff;
   hlj_pkg::week_type  out_week_ff;
   hlj_pkg::code_type  out_code_ff;
   hlj_pkg::total_type out_best_ff;
   logic               out_last_ff;
   logic               out_trunc_ff;

   hlj_pkg::code_type  choice_mem [hlj_pkg::MAX_WEEKS];
   hlj_pkg::code_type  rd_data_ff;
   hlj_pkg::week_type  rd_addr;

   hlj_pkg::best_type  final_best;
   logic               slot_free;
   logic               emit;

   assign final_best = hlj_pkg::pick_best(totals.low, totals.high, totals.none);
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign emit       = (state_ff == RUN) && slot_free;
   assign clear      = (state_ff == PRIME);
   assign busy       = (state_ff != IDLE);

   // Read ahead: the entry of the next week once the current one goes out
   always_comb begin
      unique case (state_ff)
         PRIME:   rd_addr = hlj_pkg::WEEK_BITS'(totals.count - hlj_pkg::COUNT_BITS'(1));
         RUN:     rd_addr = emit ? (pos_ff - hlj_pkg::WEEK_BITS'(1)) : pos_ff;
         default: rd_addr = pos_ff;
      endcase
   end

   // Choice memory: one write port from the forward pass, one registered read
   always_ff @(posedge clock) begin
      if (choice_wr.en) begin
         choice_mem[choice_wr.addr] <= choice_wr.code;
      end
      rd_data_ff <= choice_mem[rd_addr];
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         choice_ff    <= hlj_pkg::CODE_LOW;
      end else begin
         // Load a new transfer or drop the taken one
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= PRIME;
               end
            end
            PRIME: begin
               pos_ff    <= hlj_pkg::WEEK_BITS'(totals.count - hlj_pkg::COUNT_BITS'(1));
               choice_ff <= final_best.code;
               best_ff   <= final_best.value;
               trunc_ff  <= totals.overflow;
               state_ff  <= RUN;
            end
            RUN: begin
               if (emit) begin
                  out_week_ff  <= pos_ff;
                  out_code_ff  <= choice_ff;
                  out_best_ff  <= best_ff;
                  out_last_ff  <= (pos_ff == '0);
                  out_trunc_ff <= trunc_ff;
                  if (pos_ff == '0) begin
                     state_ff <= IDLE;
                  end else begin
                     pos_ff    <= pos_ff - hlj_pkg::WEEK_BITS'(1);
                     choice_ff <= (choice_ff == hlj_pkg::CODE_HIGH) ? hlj_pkg::CODE_NONE
                                                                    : rd_data_ff;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {1'b0, out_trunc_ff, out_best_ff, out_code_ff, out_week_ff};

endmodule

// ===== design/high_low_job_dp_traceback.sv =====
// High/low job planner with traceback.
//
// Input channel (req_): one transfer per week carries the low-stress and
// high-stress payoffs; req_tlast marks the final week of a plan. Weeks after
// the 64th are dropped and flag the run as truncated.
// Result channel (rsp_): after the final week, one transfer per stored week,
// from the last week down to week 0. Each gives the week index, its decision
// (0 low, 1 high, 2 none), the plan's best total and the truncated flag;
// rsp_tlast is set on the week 0 transfer.
//
// Timing: a non-final week is taken at once and gives no result. After the
// final week, the PRIME state picks the best total and starts the first read
// of the choice memory; then results follow one per cycle while the receiver
// keeps up, set by the single read port of that memory. The input is held off
// (req_tready low) from the final week until the last result has entered the
// output register. A stalled receiver freezes the traceback; the output
// register holds its transfer until taken.
// Reset clears totals, week count and sequencer; the choice memory needs no
// clearing, since only weeks written in the same run are read.
module high_low_job_dp_traceback (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // low_payoff, high_payoff
   input  logic        req_tlast,   // last_week
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // week_index, decision, best_total, truncated
   output logic        rsp_tlast    // last_of_run
);

   logic                   busy;
   logic                   clear;
   logic                   req_xfer;
   hlj_pkg::totals_type    totals;
   hlj_pkg::choice_wr_type choice_wr;

   // Accept a week only while no traceback is in flight
   assign req_tready = !busy;
   assign req_xfer   = req_tvalid && !busy;

   hlj_forward u_forward (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_xfer),
      .low_payoff  (req_tdata[15:0]),
      .high_payoff (req_tdata[31:16]),
      .clear       (clear),
      .totals      (totals),
      .choice_wr   (choice_wr)
   );

   hlj_trace u_trace (
      .clock      (clock),
      .reset      (reset),
      .start      (req_xfer && req_tlast),
      .totals     (totals),
      .choice_wr  (choice_wr),
      .clear      (clear),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== design/hlj_checker.sv =====
module hlj_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // Hold a stalled result
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // End of run falls exactly on week 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[5:0] == 6'd0)))
      else $error("run end not on week 0");

   // Go busy after the final week
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken during traceback");

   // Weeks count down within a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata[5:0] == $past(rsp_tdata[5:0]) - 6'd1))
      else $error("week index not descending");

   // Best total stays fixed within a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata[29:8] == $past(rsp_tdata[29:8])))
      else $error("best total changed within run");

endmodule

bind high_low_job_dp_traceback hlj_checker u_hlj_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/high_low_job_dp_traceback_tb.sv =====
`timescale 1ns / 100ps

module high_low_job_dp_traceback_tb;

   localparam int RUN_ITEMS    = 350;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;
   localparam int DIRECTED_ROWS = 20;

   // One traced-back decision as it should leave the result channel
   typedef struct {
      hlj_pkg::week_type  week;
      hlj_pkg::code_type  decision;
      hlj_pkg::total_type total;
      logic               last_of_run;
      logic               truncated;
   } decision_item_type;

   // One week of directed stimulus; typed rows carry their single result
   typedef struct packed {
      hlj_pkg::payoff_type low;
      hlj_pkg::payoff_type high;
      logic                last_week;
      logic                typed;
      hlj_pkg::code_type   decision;
      hlj_pkg::total_type  total;
   } week_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // low_payoff, high_payoff
   logic        req_tlast = 1'b0; // last_week
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // week_index, decision, best_total, truncated
   logic        rsp_tlast;        // last_of_run

   // Plan state of the predictor
   hlj_pkg::total_type plan_low;
   hlj_pkg::total_type plan_high;
   hlj_pkg::total_type plan_none;
   hlj_pkg::code_type  plan_choice [hlj_pkg::MAX_WEEKS];
   int                 plan_weeks;
   logic               plan_dropped;

   decision_item_type pending_decisions[$];
   decision_item_type seen_item;
   week_row_type      directed_rows [DIRECTED_ROWS];
   int                fail_count = 0;
   int                cycle_count = 0;
   int                burst_left = 1;
   logic [11:0]       stall_phase = '0;

   high_low_job_dp_traceback i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Largest of three totals; low wins ties over high, both over none
   function automatic void best_of(input hlj_pkg::total_type lo,
                                   input hlj_pkg::total_type hi,
                                   input hlj_pkg::total_type no,
                                   output hlj_pkg::total_type value,
                                   output hlj_pkg::code_type code);
      value = lo;
      code  = hlj_pkg::CODE_LOW;
      if (hi > value) begin
         value = hi;
         code  = hlj_pkg::CODE_HIGH;
      end
      if (no > value) begin
         value = no;
         code  = hlj_pkg::CODE_NONE;
      end
   endfunction

   function automatic hlj_pkg::total_type clip_total(input longint unsigned sum);
      return (sum > longint'(hlj_pkg::TOTAL_MAX)) ? hlj_pkg::TOTAL_MAX
                                                 : hlj_pkg::total_type'(sum);
   endfunction

   // Advance the plan by one week; on the final week queue the traceback
   function void plan_week(input hlj_pkg::payoff_type low, input hlj_pkg::payoff_type high,
                           input logic last_week);
      hlj_pkg::total_type prev;
      hlj_pkg::total_type best;
      hlj_pkg::code_type  code;
      decision_item_type  item;
      int                 w;
      if (plan_weeks >= hlj_pkg::MAX_WEEKS) begin
         plan_dropped = 1'b1;
      end else if (plan_weeks == 0) begin
         plan_low       = clip_total(longint'(low));
         plan_high      = clip_total(longint'(high));
         plan_none      = '0;
         plan_choice[0] = hlj_pkg::CODE_NONE;
         plan_weeks     = 1;
      end else begin
         best_of(plan_low, plan_high, plan_none, prev, code);
         plan_low  = clip_total(longint'(low) + longint'(prev));
         plan_high = clip_total(longint'(high) + longint'(plan_none));
         plan_none = prev;
         plan_choice[plan_weeks] = code;
         plan_weeks++;
      end
      if (last_week) begin
         best_of(plan_low, plan_high, plan_none, best, code);
         for (w = plan_weeks - 1; w >= 0; w--) begin
            item.week        = hlj_pkg::week_type'(w);
            item.decision    = code;
            item.total       = best;
            item.last_of_run = (w == 0);
            item.truncated   = plan_dropped;
            pending_decisions.insert(pending_decisions.size(), item);
            // A high week forces no job the week before
            if (w > 0) code = (code == hlj_pkg::CODE_HIGH) ? hlj_pkg::CODE_NONE : plan_choice[w];
         end
         plan_low     = '0;
         plan_high    = '0;
         plan_none    = '0;
         plan_weeks   = 0;
         plan_dropped = 1'b0;
      end
   endfunction

   function automatic hlj_pkg::payoff_type pick_payoff();
      unique case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return hlj_pkg::payoff_type'($urandom_range(0, 15));
         3:       return hlj_pkg::payoff_type'(1) << $urandom_range(0, hlj_pkg::PAYOFF_BITS - 1);
         default: return hlj_pkg::payoff_type'($urandom);
      endcase
   endfunction

   // Drive one week, hold until the transfer, then idle between bursts
   task send_week(input hlj_pkg::payoff_type low, input hlj_pkg::payoff_type high,
                  input logic last_week);
      req_tvalid <= 1'b1;
      req_tdata  <= {high, low};
      req_tlast  <= last_week;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      plan_week(low, high, last_week);
      burst_left--;
      if (burst_left <= 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   function void check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endfunction

   // Receiver stalls: steady, coin flip, periodic and slow square wave
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      unique case (stall_phase[9:8])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (stall_phase[2:0] != 3'd0);
         2'd3: rsp_tready <= stall_phase[3];
      endcase
   end

   // Compare each result transfer with the oldest queued decision
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_decisions.size() == 0) begin
            $error("unexpected result transfer for week %0d", rsp_tdata[5:0]);
            fail_count++;
         end else begin
            seen_item = pending_decisions.pop_front();
            check_field("week_index", int'(seen_item.week), int'(rsp_tdata[5:0]));
            check_field("decision", int'(seen_item.decision), int'(rsp_tdata[7:6]));
            check_field("best_total", int'(seen_item.total), int'(rsp_tdata[29:8]));
            check_field("truncated", int'(seen_item.truncated), int'(rsp_tdata[30]));
            check_field("last_of_run", int'(seen_item.last_of_run), int'(rsp_tlast));
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int                i;
      int                plan;
      int                span;
      int                sent;
      week_row_type      row;
      decision_item_type typed_item;

      // Every week goes to the predictor; single-week plans carry their result, which replaces the predictor's entry
      directed_rows = '{
         '{16'hFFFF, 16'h0000, 1'b1, 1'b1, hlj_pkg::CODE_LOW,  22'h00FFFF},
         '{16'h0000, 16'hFFFF, 1'b1, 1'b1, hlj_pkg::CODE_HIGH, 22'h00FFFF},
         '{16'h0000, 16'h0000, 1'b1, 1'b1, hlj_pkg::CODE_LOW,  22'h000000},
         '{16'h1234, 16'h1234, 1'b1, 1'b1, hlj_pkg::CODE_LOW,  22'h001234},
         '{16'h0000, 16'h8000, 1'b1, 1'b1, hlj_pkg::CODE_HIGH, 22'h008000},
         '{16'h000A, 16'h0001, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0001, 16'h0064, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0003, 16'h0002, 1'b1, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0000, 16'hFFFF, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0000, 16'hFFFF, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0000, 16'hFFFF, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0000, 16'hFFFF, 1'b1, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'hFFFF, 16'hFFFF, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0000, 16'h0000, 1'b1, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0007, 16'h0014, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0007, 16'h0014, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h0005, 16'h0005, 1'b1, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'h5555, 16'hAAAA, 1'b0, 1'b0, hlj_pkg::CODE_LOW,  22'h0},
         '{16'hAAAA, 16'h5555, 1'b1, 1'b0, hlj_pkg::CODE_LOW,  22'h0}
      };
      plan_low     = '0;
      plan_high    = '0;
      plan_none    = '0;
      plan_weeks   = 0;
      plan_dropped = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed weeks
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_rows[i];
         send_week(row.low, row.high, row.last_week);
         if (row.typed) begin
            typed_item.week        = '0;
            typed_item.decision    = row.decision;
            typed_item.total       = row.total;
            typed_item.last_of_run = 1'b1;
            typed_item.truncated   = 1'b0;
            pending_decisions[$]   = typed_item;
         end
      end

      // Random plans: first one overruns capacity, second fills it exactly
      sent = 0;
      plan = 0;
      while (sent < RUN_ITEMS) begin
         if (plan == 0)
            span = 66;
         else if (plan == 1)
            span = hlj_pkg::MAX_WEEKS;
         else if ($urandom_range(0, 15) == 0)
            span = $urandom_range(60, 70);
         else
            span = $urandom_range(1, 10);
         for (i = 0; i < span; i++) begin
            send_week(pick_payoff(), pick_payoff(), i == span - 1);
         end
         sent += span;
         plan++;
      end
      req_tvalid <= 1'b0;

      // Drain the remaining traceback, then allow for stray transfers
      while (pending_decisions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
